/* rtl/core/rpi_pkg.sv */
// shared constants, payload types and status structs for the ray-plane intersection block
package rpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XW        = 32;
    localparam int PROD_W    = 2 * XW;
    localparam int SUM_W     = PROD_W + 3;
    localparam int MAG_W     = PROD_W;
    localparam int DIV_W     = MAG_W + FRAC_BITS;
    localparam int QK_W      = XW + FRAC_BITS;
    localparam int QL_W      = QK_W / 2;
    localparam int QU_W      = QK_W - QL_W;
    localparam int MP_W      = QK_W + XW;
    localparam int FQ_DEPTH  = 4;
    localparam int FQ_AW     = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_AW     = $clog2(OQ_DEPTH);

    typedef logic [2:0][XW-1:0] t_vec3;

    typedef struct packed {
        logic signed [XW-1:0] normal_x;
        logic signed [XW-1:0] normal_y;
        logic signed [XW-1:0] normal_z;
        logic signed [XW-1:0] plane_offset;
        logic signed [XW-1:0] origin_x;
        logic signed [XW-1:0] origin_y;
        logic signed [XW-1:0] origin_z;
        logic signed [XW-1:0] dir_x;
        logic signed [XW-1:0] dir_y;
        logic signed [XW-1:0] dir_z;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic signed [XW-1:0] point_x;
        logic signed [XW-1:0] point_y;
        logic signed [XW-1:0] point_z;
    } t_out_item;

    typedef struct packed {
        logic             live;
        logic [MAG_W-1:0] anum;
        logic [MAG_W-1:0] aden;
        t_vec3            o;
        t_vec3            d;
    } t_mid;

    typedef struct packed {
        logic             live;
        logic [DIV_W-1:0] q;
        t_vec3            o;
        t_vec3            d;
    } t_div_out;

    typedef struct packed {
        logic nonempty;
        logic full;
    } t_fq_stat;

    typedef struct packed {
        logic en;
        logic oq_full;
    } t_back_stat;

endpackage

/* rtl/core/rpi_front.sv */
// front end: products, plane terms, classification and the queue toward the divider
module rpi_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rpi_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output rpi_pkg::t_mid     o_head,
    output rpi_pkg::t_fq_stat o_stat
);
    import rpi_pkg::*;

    logic                    r_s1_v;
    logic signed [PROD_W-1:0] r_nd [3];
    logic signed [PROD_W-1:0] r_on [3];
    logic signed [XW-1:0]    r_off;
    t_vec3                   r_o;
    t_vec3                   r_d;

    t_vec3                   w_n;
    t_vec3                   w_oi;
    t_vec3                   w_di;
    logic signed [SUM_W-1:0] w_den;
    logic signed [SUM_W-1:0] w_osum;
    logic signed [SUM_W-1:0] w_num;
    logic [SUM_W-1:0]        w_anum;
    logic [SUM_W-1:0]        w_aden;
    t_mid                    w_entry;

    t_mid                    r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]        r_wp;
    logic [FQ_AW-1:0]        r_rp;
    logic [FQ_AW:0]          r_cnt;
    logic                    w_fq_full;
    logic                    w_fq_push;
    logic                    w_fq_pop;
    logic                    w_accept;

    assign w_n  = {i_item.normal_z, i_item.normal_y, i_item.normal_x};
    assign w_oi = {i_item.origin_z, i_item.origin_y, i_item.origin_x};
    assign w_di = {i_item.dir_z, i_item.dir_y, i_item.dir_x};

    assign w_fq_full = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign w_fq_push = r_s1_v && !w_fq_full;
    assign w_fq_pop  = i_pop && (r_cnt != '0);
    assign o_full    = r_s1_v && w_fq_full;
    assign w_accept  = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_accept) begin
            r_s1_v <= 1'b1;
        end else if (w_fq_push) begin
            r_s1_v <= 1'b0;
        end
        if (w_accept) begin
            for (int k = 0; k < 3; k++) begin
                r_nd[k] <= $signed(w_n[k]) * $signed(w_di[k]);
                r_on[k] <= $signed(w_oi[k]) * $signed(w_n[k]);
            end
            r_off <= i_item.plane_offset;
            r_o   <= w_oi;
            r_d   <= w_di;
        end
    end

    always_comb begin
        w_den  = SUM_W'(r_nd[0]) + SUM_W'(r_nd[1]) + SUM_W'(r_nd[2]);
        w_osum = SUM_W'(r_on[0]) + SUM_W'(r_on[1]) + SUM_W'(r_on[2]);
        w_num  = SUM_W'(0) - (w_osum + (SUM_W'(r_off) <<< FRAC_BITS));
        w_anum = w_num[SUM_W-1] ? SUM_W'(0) - w_num : w_num;
        w_aden = w_den[SUM_W-1] ? SUM_W'(0) - w_den : w_den;
        w_entry.live = (w_den != '0) && (w_num != '0) && (w_num[SUM_W-1] == w_den[SUM_W-1]);
        w_entry.anum = w_anum[MAG_W-1:0];
        w_entry.aden = w_aden[MAG_W-1:0];
        w_entry.o    = r_o;
        w_entry.d    = r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_fq_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_fq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_fq_push && !w_fq_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_fq_push && w_fq_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_fq_push) begin
            r_mem[r_wp] <= w_entry;
        end
    end

    assign o_head          = r_mem[r_rp];
    assign o_stat.nonempty = (r_cnt != '0);
    assign o_stat.full     = w_fq_full;

endmodule

/* rtl/core/rpi_divider.sv */
// pipelined restoring divider, one quotient bit per stage
module rpi_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rpi_pkg::t_mid     i_head,
    output logic              o_valid,
    output rpi_pkg::t_div_out o_res
);
    import rpi_pkg::*;

    logic             r_v    [DIV_W+1];
    logic [MAG_W-1:0] r_rem  [DIV_W+1];
    logic [DIV_W-1:0] r_dq   [DIV_W+1];
    logic [MAG_W-1:0] r_aden [DIV_W+1];
    logic             r_live [DIV_W+1];
    t_vec3            r_o    [DIV_W+1];
    t_vec3            r_d    [DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= '0;
            r_dq[0]   <= {i_head.anum, FRAC_BITS'(0)};
            r_aden[0] <= i_head.aden;
            r_live[0] <= i_head.live;
            r_o[0]    <= i_head.o;
            r_d[0]    <= i_head.d;
        end
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_step
        logic [MAG_W:0] w_t;
        logic           w_ge;
        logic [MAG_W:0] w_r;

        assign w_t  = {r_rem[k], r_dq[k][DIV_W-1]};
        assign w_ge = (w_t >= {1'b0, r_aden[k]});
        assign w_r  = w_ge ? w_t - {1'b0, r_aden[k]} : w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= w_r[MAG_W-1:0];
                r_dq[k+1]   <= {r_dq[k][DIV_W-2:0], w_ge};
                r_aden[k+1] <= r_aden[k];
                r_live[k+1] <= r_live[k];
                r_o[k+1]    <= r_o[k];
                r_d[k+1]    <= r_d[k];
            end
        end
    end

    assign o_valid    = r_v[DIV_W];
    assign o_res.live = r_live[DIV_W];
    assign o_res.q    = r_dq[DIV_W];
    assign o_res.o    = r_o[DIV_W];
    assign o_res.d    = r_d[DIV_W];

endmodule

/* rtl/core/rpi_back.sv */
// back end: point multiply, saturation and the result queue
module rpi_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rpi_pkg::t_div_out   i_res,
    output rpi_pkg::t_back_stat o_stat,
    input  logic                i_pop,
    output logic                o_empty,
    output rpi_pkg::t_out_item  o_item
);
    import rpi_pkg::*;

    logic                 r_m_v;
    logic                 r_hit;
    logic                 r_big;
    logic [QL_W+XW-1:0]   r_pl  [3];
    logic [QU_W+XW-1:0]   r_ph  [3];
    logic                 r_mnz [3];
    logic                 r_neg [3];
    t_vec3                r_o;

    logic [XW-1:0]        w_m   [3];
    logic [XW-1:0]        w_pt  [3];
    t_out_item            w_item;

    t_out_item            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]     r_wp;
    logic [OQ_AW-1:0]     r_rp;
    logic [OQ_AW:0]       r_cnt;
    logic                 w_oq_full;
    logic                 w_oq_push;
    logic                 w_oq_pop;
    logic                 w_en;

    assign w_oq_full = (r_cnt == (OQ_AW+1)'(OQ_DEPTH));
    assign w_en      = !(r_m_v && w_oq_full);
    assign w_oq_push = r_m_v && !w_oq_full;
    assign w_oq_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_m[k] = i_res.d[k][XW-1] ? XW'(0) - i_res.d[k] : i_res.d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= i_valid;
        end
        if (w_en) begin
            r_hit <= i_res.live && (i_res.q != '0);
            r_big <= (i_res.q[DIV_W-1:QK_W] != '0);
            for (int k = 0; k < 3; k++) begin
                r_pl[k]  <= (QL_W+XW)'(i_res.q[QL_W-1:0]) * (QL_W+XW)'(w_m[k]);
                r_ph[k]  <= (QU_W+XW)'(i_res.q[QK_W-1:QL_W]) * (QU_W+XW)'(w_m[k]);
                r_mnz[k] <= (w_m[k] != '0);
                r_neg[k] <= i_res.d[k][XW-1];
            end
            r_o <= i_res.o;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [MP_W-1:0]    w_prod;
        logic [2*XW-1:0]    w_p;
        logic               w_sat;
        logic signed [XW+1:0] w_s;

        assign w_prod = MP_W'(r_pl[k]) + (MP_W'(r_ph[k]) << QL_W);
        assign w_p    = w_prod[MP_W-1:FRAC_BITS];
        assign w_sat  = (r_big && r_mnz[k]) || (w_p[2*XW-1:XW] != '0);
        assign w_s    = r_neg[k] ? $signed((XW+2)'($signed(r_o[k]))) - $signed({2'b00, w_p[XW-1:0]})
                                 : $signed((XW+2)'($signed(r_o[k]))) + $signed({2'b00, w_p[XW-1:0]});

        always_comb begin
            if (!r_hit) begin
                w_pt[k] = '0;
            end else if (w_sat) begin
                w_pt[k] = r_neg[k] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
            end else if (w_s[XW+1:XW-1] == 3'b000 || w_s[XW+1:XW-1] == 3'b111) begin
                w_pt[k] = w_s[XW-1:0];
            end else begin
                w_pt[k] = w_s[XW+1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
            end
        end
    end

    assign w_item.hit     = r_hit;
    assign w_item.point_x = w_pt[0];
    assign w_item.point_y = w_pt[1];
    assign w_item.point_z = w_pt[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_oq_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_oq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_oq_push && !w_oq_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_oq_push && w_oq_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_oq_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    assign o_empty        = (r_cnt == '0);
    assign o_item         = r_mem[r_rp];
    assign o_stat.en      = w_en;
    assign o_stat.oq_full = w_oq_full;

endmodule

/* rtl/core/ray_plane_intersection.sv */
// top level of the ray-plane intersection block
//
// input side is a queue: drive i_item and raise i_push; a transfer happens at a
// clock edge with i_push high and o_full low. result side is a queue too: while
// o_empty is low the oldest result sits on o_item and i_pop takes it.
// every input gives exactly one result, in order: hit plus the intersection
// point in signed Q16.16, saturated per axis, zero point on a miss.
// throughput is one item per cycle unless a full result queue stalls the back.
// from input transfer to result visible an item passes one product stage,
// the classify queue write, DIV_W + 1 divider registers (one quotient bit
// per stage), one multiply stage and the result queue write.
// the front keeps taking items into its four-entry queue while the back is
// stalled; when the result queue is full the back pipeline holds and the
// front fills until o_full rises.
// synchronous active-low reset empties both queues and clears all valid bits;
// results are lost and nothing is produced until new items arrive.
module ray_plane_intersection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rpi_pkg::t_in_item  i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output rpi_pkg::t_out_item o_item
);
    import rpi_pkg::*;

    t_mid       w_head;
    t_fq_stat   w_fq_stat;
    t_back_stat w_b_stat;
    t_div_out   w_div_res;
    logic       w_div_v;
    logic       w_fq_pop;

    assign w_fq_pop = w_b_stat.en && w_fq_stat.nonempty;

    rpi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .i_pop   (w_fq_pop),
        .o_head  (w_head),
        .o_stat  (w_fq_stat)
    );

    rpi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_b_stat.en),
        .i_valid (w_fq_pop),
        .i_head  (w_head),
        .o_valid (w_div_v),
        .o_res   (w_div_res)
    );

    rpi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_v),
        .i_res   (w_div_res),
        .o_stat  (w_b_stat),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_item  (o_item)
    );

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_item.hit) |->
        (o_item.point_x == '0 && o_item.point_y == '0 && o_item.point_z == '0))
        else $error("miss result with nonzero point");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_b_stat.en |-> w_b_stat.oq_full)
        else $error("back stalled with room in result queue");

    a_front_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> w_fq_stat.full)
        else $error("front refuses input with room in its queue");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_empty)
        else $error("result queue not empty after reset");

endmodule

/* tb/tb_ray_plane_intersection.sv */
// testbench for the ray-plane intersection block: predicts each result and checks it in order
module tb_ray_plane_intersection;
    import rpi_pkg::*;

    class hit_scoreboard;
        t_out_item pending[$];
        int        n_err;

        function new();
            n_err = 0;
        endfunction

        function t_out_item predict(t_in_item it);
            logic signed [XW-1:0] nv[3], ov[3], dv[3];
            logic signed [127:0]  den, num, s, pr;
            logic        [127:0]  q, an, ad, m;
            t_out_item            r;
            nv = '{it.normal_x, it.normal_y, it.normal_z};
            ov = '{it.origin_x, it.origin_y, it.origin_z};
            dv = '{it.dir_x, it.dir_y, it.dir_z};
            r = '0;
            den = 0;
            num = 0;
            for (int i = 0; i < 3; i++) begin
                den += 128'(nv[i]) * 128'(dv[i]);
                num += 128'(nv[i]) * 128'(ov[i]);
            end
            num = -(num + (128'(it.plane_offset) <<< FRAC_BITS));
            if (den == 0 || num == 0 || (num < 0) != (den < 0)) return r;
            an = num < 0 ? -num : num;
            ad = den < 0 ? -den : den;
            q = (an << FRAC_BITS) / ad;
            if (q == 0) return r;
            r.hit = 1'b1;
            for (int i = 0; i < 3; i++) begin
                m = dv[i] < 0 ? -128'(dv[i]) : 128'(dv[i]);
                pr = (q * m) >> FRAC_BITS;
                if (pr[127:62] != 0) begin
                    s = dv[i] < 0 ? -128'sd2147483648 : 128'sd2147483647;
                end else begin
                    s = dv[i] < 0 ? -pr : pr;
                    s = s + 128'(ov[i]);
                    if (s > 128'sd2147483647) s = 128'sd2147483647;
                    if (s < -128'sd2147483648) s = -128'sd2147483648;
                end
                case (i)
                    0: r.point_x = s[31:0];
                    1: r.point_y = s[31:0];
                    default: r.point_z = s[31:0];
                endcase
            end
            return r;
        endfunction

        function void note_input(t_in_item it);
            pending.insert(pending.size(), predict(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", got);
                n_err++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, got.hit);
                n_err++;
            end
            if (got.point_x !== e.point_x) begin
                $error("point_x exp %0d got %0d", e.point_x, got.point_x);
                n_err++;
            end
            if (got.point_y !== e.point_y) begin
                $error("point_y exp %0d got %0d", e.point_y, got.point_y);
                n_err++;
            end
            if (got.point_z !== e.point_z) begin
                $error("point_z exp %0d got %0d", e.point_z, got.point_z);
                n_err++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_push = 1'b0;
    logic      i_pop = 1'b0;
    t_in_item  i_item = '0;
    logic      o_full, o_empty;
    t_out_item o_item;

    int            push_idle = 0;
    int            pop_idle = 0;
    int            cycles = 0;
    hit_scoreboard sb = new();

    ray_plane_intersection i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_ray_plane_intersection: done, errors");
            $finish;
        end
    end

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) sb.check_result(o_item);
        i_pop <= i_rst_n && ($urandom_range(99) >= pop_idle);
    end

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            1: return $urandom_range(1) ? 32'sd0 : 32'(32'sd1 <<< FRAC_BITS);
            2: return 32'($signed($urandom_range(16'hffff, 0)) - 32'sh8000) <<< 4;
            3: return 32'($signed($urandom_range(32'h7ffff)) - 32'sh40000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_in_item it);
        i_item <= it;
        i_push <= 1'b1;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sb.note_input(it);
        while ($urandom_range(99) < push_idle) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        t_in_item it;
        it = {rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
              rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val()};
        send(it);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // hit on z=5 plane from origin along +z
        send('{0, 0, ONE, -5 * ONE, 0, 0, 0, 0, 0, ONE});
        // parallel ray
        send('{0, 0, ONE, -5 * ONE, 0, 0, 0, ONE, 0, 0});
        // plane behind the origin
        send('{0, 0, ONE, 5 * ONE, 0, 0, 0, 0, 0, ONE});
        // origin on the plane
        send('{0, 0, ONE, 0, 3 * ONE, 0, 0, 0, 0, ONE});
        // t truncates to zero
        send('{0, 0, ONE, -1, 0, 0, 0, 0, 0, 32'h7fffffff});
        // huge t, saturating point both ways
        send('{0, 0, 1, 32'h80000000, 0, 0, 0, 32'h7fffffff, 32'h80000000, 1});
        send('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h7fffffff, 32'h80000000});
        send('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff});
        send('{32'hffffffff, 0, 0, 32'h7fffffff, 32'hffffffff, 0, 0, 32'hffffffff, 0, 0});
        send('1);
        send('0);
        for (int ph = 0; ph < 3; ph++) begin
            push_idle = ph == 0 ? 23 : (ph == 1 ? 60 : 0);
            pop_idle  = ph == 0 ? 60 : (ph == 1 ? 23 : 0);
            for (int n = 0; n < 530; n++) send_random();
        end
        i_push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (sb.n_err == 0) $display("tb_ray_plane_intersection: done, clean");
        else $display("tb_ray_plane_intersection: done, errors");
        $finish;
    end
endmodule
